// ===== src/lzwcd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzwcd_pkg
// Shared types and constants of the window-copy decoder: item structs,
// history sizing, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package lzwcd_pkg;

	localparam int HISTORY_DEPTH = 32;
	localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
	localparam int FILL_W        = HIST_AW + 1;

	localparam logic [7:0] ESCAPE_CODE = 8'hFF;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       chunk_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       bad_run;
		logic       chunk_done;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_COPY
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic drop_item;
		logic set_escape;
		logic emit_literal;
		logic emit_error;
		logic start_copy;
		logic emit_copy;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic discarding;
		logic escape_pending;
		logic code_is_escape;
		logic chunk_end;
		logic copy_bad;
		logic slot_free;
		logic copy_final;
	} sts_t;

endpackage

// ===== src/lz_window_copy_decoder.sv =====
// ----------------------------------------------------------------------------
// lz_window_copy_decoder
// Path: a taken item is registered in the input register; a literal or error result
//   is then registered in the output register, a copy byte via the RAM read register.
// Throughput: no new item is taken until the last is done (copies of up to 8 bytes);
//   one history RAM read port gives one copied byte per cycle while the output is free.
// Reset: clears chunk state and the sequencer; no clearing pass is run, and
//   history contents stay undefined until written within a chunk.
// ----------------------------------------------------------------------------
module lz_window_copy_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 code_valid,
	output logic                 code_ready,
	input  lzwcd_pkg::in_item_t  code,
	output logic                 result_valid,
	input  logic                 result_ready,
	output lzwcd_pkg::out_item_t result
);

	lzwcd_pkg::cmd_t cmd;
	lzwcd_pkg::sts_t sts;

	// sequencer
	lzwcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.code_valid(code_valid),
		.code_ready(code_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// history, pointers and result register
	lzwcd_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.code        (code),
		.cmd         (cmd),
		.sts         (sts),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

endmodule

// ===== src/lzwcd_ram.sv =====
// ----------------------------------------------------------------------------
// lzwcd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lzwcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read; hold the last word when not reading
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/lzwcd_datapath.sv =====
// ----------------------------------------------------------------------------
// lzwcd_datapath
// Input register, history RAM, window pointers, chunk state and the output
// register. Acts on the commands of the controller and reports status.
// ----------------------------------------------------------------------------
module lzwcd_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lzwcd_pkg::in_item_t  code,
	input  lzwcd_pkg::cmd_t      cmd,
	output lzwcd_pkg::sts_t      sts,
	output logic                 result_valid,
	input  logic                 result_ready,
	output lzwcd_pkg::out_item_t result
);

	lzwcd_pkg::in_item_t  in_q;
	lzwcd_pkg::out_item_t out_q;
	lzwcd_pkg::out_item_t out_d;
	logic                 out_valid_q;
	logic                 out_load;

	logic [lzwcd_pkg::HIST_AW-1:0] wr_pos_q;
	logic [lzwcd_pkg::FILL_W-1:0]  fill_q;
	logic                          escape_q;
	logic                          discard_q;
	logic [2:0]                    remain_q;
	logic [lzwcd_pkg::HIST_AW-1:0] rd_ptr_q;

	logic [lzwcd_pkg::FILL_W-1:0]  copy_dist;
	logic [lzwcd_pkg::FILL_W-1:0]  len;
	logic [lzwcd_pkg::HIST_AW-1:0] copy_start;
	logic [lzwcd_pkg::HIST_AW-1:0] rd_addr;
	logic                          rd_en;
	logic                          wr_en;
	logic [7:0]                    wr_data;
	logic [7:0]                    rd_data;
	logic                          advance;
	logic                          end_chunk;

	// decode distance and length of a copy code
	assign copy_dist = lzwcd_pkg::FILL_W'(lzwcd_pkg::HISTORY_DEPTH)
		- {1'b0, in_q.code_byte[7:3]};
	assign len = lzwcd_pkg::FILL_W'({3'b000, in_q.code_byte[2:0]})
		+ lzwcd_pkg::FILL_W'(1);
	assign copy_start = wr_pos_q - copy_dist[lzwcd_pkg::HIST_AW-1:0];

	// status towards the controller
	always_comb begin
		sts.discarding     = discard_q;
		sts.escape_pending = escape_q;
		sts.code_is_escape = (in_q.code_byte == lzwcd_pkg::ESCAPE_CODE);
		sts.chunk_end      = in_q.chunk_end;
		sts.copy_bad       = (copy_dist > fill_q) || (len > copy_dist);
		sts.slot_free      = !out_valid_q || result_ready;
		sts.copy_final     = (remain_q == 3'd0);
	end

	// history RAM access: literal or copied byte written, next copy byte read
	assign wr_en   = cmd.emit_literal || cmd.emit_copy;
	assign wr_data = cmd.emit_copy ? rd_data : in_q.code_byte;
	assign rd_en   = cmd.start_copy || (cmd.emit_copy && (remain_q != 3'd0));
	assign rd_addr = cmd.start_copy ? copy_start : rd_ptr_q;
	assign advance = wr_en;

	lzwcd_ram #(
		.WIDTH(8),
		.DEPTH(lzwcd_pkg::HISTORY_DEPTH)
	) u_history (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_pos_q),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// chunk ends after its last item is dealt with
	assign end_chunk = in_q.chunk_end && (cmd.drop_item || cmd.emit_literal
		|| cmd.emit_error || (cmd.emit_copy && (remain_q == 3'd0)));

	// build the next result
	assign out_load = cmd.emit_literal || cmd.emit_error || cmd.emit_copy;
	always_comb begin
		out_d = '0;
		if (cmd.emit_literal) begin
			out_d.out_byte   = in_q.code_byte;
			out_d.run_last   = 1'b1;
			out_d.chunk_done = in_q.chunk_end;
		end else if (cmd.emit_error) begin
			out_d.run_last   = 1'b1;
			out_d.bad_run    = 1'b1;
			out_d.chunk_done = in_q.chunk_end;
		end else begin
			out_d.out_byte   = rd_data;
			out_d.run_last   = (remain_q == 3'd0);
			out_d.chunk_done = (remain_q == 3'd0) && in_q.chunk_end;
		end
	end

	// hold payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q <= code;
		end
		if (out_load) begin
			out_q <= out_d;
		end
		if (cmd.start_copy) begin
			rd_ptr_q <= copy_start + lzwcd_pkg::HIST_AW'(1);
		end else if (rd_en) begin
			rd_ptr_q <= rd_ptr_q + lzwcd_pkg::HIST_AW'(1);
		end
	end

	// advance chunk state and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			wr_pos_q    <= '0;
			fill_q      <= '0;
			escape_q    <= 1'b0;
			discard_q   <= 1'b0;
			remain_q    <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cmd.start_copy) begin
				remain_q <= in_q.code_byte[2:0];
			end else if (cmd.emit_copy && (remain_q != 3'd0)) begin
				remain_q <= remain_q - 3'd1;
			end

			if (end_chunk) begin
				wr_pos_q  <= '0;
				fill_q    <= '0;
				escape_q  <= 1'b0;
				discard_q <= 1'b0;
			end else begin
				if (advance) begin
					wr_pos_q <= wr_pos_q + lzwcd_pkg::HIST_AW'(1);
					if (fill_q != lzwcd_pkg::FILL_W'(lzwcd_pkg::HISTORY_DEPTH)) begin
						fill_q <= fill_q + lzwcd_pkg::FILL_W'(1);
					end
				end
				if (cmd.set_escape) begin
					escape_q <= 1'b1;
				end else if (cmd.emit_literal) begin
					escape_q <= 1'b0;
				end
				if (cmd.emit_error) begin
					discard_q <= 1'b1;
				end
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== src/lzwcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lzwcd_ctrl
// Sequencer of the decoder: takes an item, picks its action from the status
// of the datapath and steps through the bytes of a copy.
// ----------------------------------------------------------------------------
module lzwcd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              code_valid,
	output logic              code_ready,
	input  lzwcd_pkg::sts_t   sts,
	output lzwcd_pkg::cmd_t   cmd
);

	lzwcd_pkg::state_t state_q;
	lzwcd_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzwcd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lzwcd_pkg::ST_IDLE: begin
				if (code_valid) begin
					state_d = lzwcd_pkg::ST_DECODE;
				end
			end
			lzwcd_pkg::ST_DECODE: begin
				if (sts.discarding) begin
					state_d = lzwcd_pkg::ST_IDLE;
				end else if (sts.escape_pending) begin
					if (sts.slot_free) begin
						state_d = lzwcd_pkg::ST_IDLE;
					end
				end else if (sts.code_is_escape && !sts.chunk_end) begin
					state_d = lzwcd_pkg::ST_IDLE;
				end else if (sts.code_is_escape || sts.copy_bad) begin
					if (sts.slot_free) begin
						state_d = lzwcd_pkg::ST_IDLE;
					end
				end else begin
					state_d = lzwcd_pkg::ST_COPY;
				end
			end
			lzwcd_pkg::ST_COPY: begin
				if (sts.slot_free && sts.copy_final) begin
					state_d = lzwcd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lzwcd_pkg::ST_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd        = '0;
		code_ready = 1'b0;
		case (state_q)
			lzwcd_pkg::ST_IDLE: begin
				code_ready  = 1'b1;
				cmd.load_in = code_valid;
			end
			lzwcd_pkg::ST_DECODE: begin
				if (sts.discarding) begin
					cmd.drop_item = 1'b1;
				end else if (sts.escape_pending) begin
					cmd.emit_literal = sts.slot_free;
				end else if (sts.code_is_escape && !sts.chunk_end) begin
					cmd.set_escape = 1'b1;
				end else if (sts.code_is_escape || sts.copy_bad) begin
					cmd.emit_error = sts.slot_free;
				end else begin
					cmd.start_copy = 1'b1;
				end
			end
			lzwcd_pkg::ST_COPY: begin
				cmd.emit_copy = sts.slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
